@@ hdl/taqe_pkg.sv @@
// shared types and constants for the tree ancestor query engine
package taqe_pkg;

  localparam int NODE_W    = 10;
  localparam int DIST_W    = 11;
  localparam int DEPTH_SPAN = 1024;
  localparam logic [NODE_W-1:0] DEPTH_MAX = 10'h3FF;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_ANC  = 2'd1,
    KIND_LCA  = 2'd2,
    KIND_DIST = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] steps;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] result_node;
    logic [DIST_W-1:0] result_distance;
    logic              status;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_FAIL,
    OP_ROOT_WR,
    OP_RD_DEP_B,
    OP_LD_DW,
    OP_RD_JU_LVL,
    OP_LD_JW,
    OP_RD_DEP_A,
    OP_Q_SET,
    OP_RD_JC_TOP,
    OP_C_TOPW,
    OP_C_SETBIT,
    OP_RD_JC_LVL,
    OP_C_BITW,
    OP_LVL_DEC,
    OP_DU_RD_B,
    OP_EQ_SET,
    OP_RD_JU_TOP,
    OP_T_RV,
    OP_T_STEP,
    OP_B_RV,
    OP_B_STEP,
    OP_F_W,
    OP_RD_DEP_U,
    OP_DONE_NODE,
    OP_DONE_LOAD,
    OP_DONE_DIST
  } dp_op_t;

  typedef struct packed {
    logic       bad_req;
    logic       root_load;
    logic [1:0] kind;
    logic       step_over;
    logic       k_ge_top;
    logic       node_c_null;
    logic       k_bit;
    logic       lvl_zero;
    logic       lvl_last;
    logic       lvl_pen;
    logic       uv_eq;
    logic       rep_done;
    logic       p_eq;
    logic       u_zero;
  } dp_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROOT,
    ST_L_DR,
    ST_L_DW,
    ST_L_JR,
    ST_L_JW,
    ST_OUT_LOAD,
    ST_Q_DR,
    ST_Q_DC,
    ST_C_TOP,
    ST_C_TOPW,
    ST_C_BIT,
    ST_C_BITW,
    ST_OUT_NODE,
    ST_D_RA,
    ST_D_RB,
    ST_D_CMP,
    ST_A_EQ,
    ST_T_RU,
    ST_T_RV,
    ST_T_CMP,
    ST_B_INIT,
    ST_B_RU,
    ST_B_RV,
    ST_B_CMP,
    ST_F_RU,
    ST_F_W,
    ST_W_CHK,
    ST_X_D
  } state_t;

endpackage

@@ hdl/taqe_ctrl.sv @@
// controller state machine sequencing loads and queries
module taqe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  taqe_pkg::dp_sts_t sts,
  output taqe_pkg::dp_op_t  op
);
  import taqe_pkg::*;

  state_t state_r, state_nxt;
  state_t ret_st;

  assign busy   = (state_r != ST_IDLE);
  assign ret_st = (sts.kind == KIND_ANC) ? ST_OUT_NODE : ST_A_EQ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.bad_req) state_nxt = ST_IDLE;
        else if (sts.kind == KIND_LOAD) state_nxt = sts.root_load ? ST_ROOT : ST_L_DR;
        else if (sts.kind == KIND_ANC) state_nxt = ST_Q_DR;
        else state_nxt = ST_D_RA;
      end
      ST_ROOT:     if (sts.lvl_last) state_nxt = ST_OUT_LOAD;
      ST_L_DR:     state_nxt = ST_L_DW;
      ST_L_DW:     state_nxt = ST_L_JR;
      ST_L_JR:     state_nxt = ST_L_JW;
      ST_L_JW:     state_nxt = sts.lvl_pen ? ST_OUT_LOAD : ST_L_JR;
      ST_OUT_LOAD: state_nxt = ST_IDLE;
      ST_Q_DR:     state_nxt = ST_Q_DC;
      ST_Q_DC:     state_nxt = sts.step_over ? ST_IDLE : ST_C_TOP;
      ST_C_TOP: begin
        state_nxt = (sts.k_ge_top && !sts.node_c_null) ? ST_C_TOPW : ST_C_BIT;
      end
      ST_C_TOPW:   state_nxt = ST_C_TOP;
      ST_C_BIT: begin
        if (sts.k_bit && !sts.node_c_null) state_nxt = ST_C_BITW;
        else if (sts.lvl_zero) state_nxt = ret_st;
      end
      ST_C_BITW:   state_nxt = sts.lvl_zero ? ret_st : ST_C_BIT;
      ST_OUT_NODE: state_nxt = ST_IDLE;
      ST_D_RA:     state_nxt = ST_D_RB;
      ST_D_RB:     state_nxt = ST_D_CMP;
      ST_D_CMP:    state_nxt = ST_C_TOP;
      ST_A_EQ:     state_nxt = sts.uv_eq ? ST_W_CHK : ST_T_RU;
      ST_T_RU:     state_nxt = sts.rep_done ? ST_B_INIT : ST_T_RV;
      ST_T_RV:     state_nxt = ST_T_CMP;
      ST_T_CMP:    state_nxt = sts.p_eq ? ST_B_INIT : ST_T_RU;
      ST_B_INIT:   state_nxt = ST_B_RU;
      ST_B_RU:     state_nxt = ST_B_RV;
      ST_B_RV:     state_nxt = ST_B_CMP;
      ST_B_CMP:    state_nxt = sts.lvl_zero ? ST_F_RU : ST_B_RU;
      ST_F_RU:     state_nxt = ST_F_W;
      ST_F_W:      state_nxt = ST_W_CHK;
      ST_W_CHK: begin
        if (sts.u_zero || sts.kind == KIND_LCA) state_nxt = ST_IDLE;
        else state_nxt = ST_X_D;
      end
      ST_X_D:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    case (state_r)
      ST_IDLE:     if (start) op = OP_LATCH;
      ST_CHECK:    if (sts.bad_req) op = OP_FAIL;
      ST_ROOT:     op = OP_ROOT_WR;
      ST_L_DR:     op = OP_RD_DEP_B;
      ST_L_DW:     op = OP_LD_DW;
      ST_L_JR:     op = OP_RD_JU_LVL;
      ST_L_JW:     op = OP_LD_JW;
      ST_OUT_LOAD: op = OP_DONE_LOAD;
      ST_Q_DR:     op = OP_RD_DEP_A;
      ST_Q_DC:     op = sts.step_over ? OP_FAIL : OP_Q_SET;
      ST_C_TOP:    op = (sts.k_ge_top && !sts.node_c_null) ? OP_RD_JC_TOP : OP_C_SETBIT;
      ST_C_TOPW:   op = OP_C_TOPW;
      ST_C_BIT: begin
        if (sts.k_bit && !sts.node_c_null) op = OP_RD_JC_LVL;
        else if (!sts.lvl_zero) op = OP_LVL_DEC;
      end
      ST_C_BITW:   op = OP_C_BITW;
      ST_OUT_NODE: op = OP_DONE_NODE;
      ST_D_RA:     op = OP_RD_DEP_A;
      ST_D_RB:     op = OP_DU_RD_B;
      ST_D_CMP:    op = OP_EQ_SET;
      ST_T_RU:     if (!sts.rep_done) op = OP_RD_JU_TOP;
      ST_T_RV:     op = OP_T_RV;
      ST_T_CMP:    if (!sts.p_eq) op = OP_T_STEP;
      ST_B_INIT:   op = OP_C_SETBIT;
      ST_B_RU:     op = OP_RD_JU_LVL;
      ST_B_RV:     op = OP_B_RV;
      ST_B_CMP:    op = OP_B_STEP;
      ST_F_RU:     op = OP_RD_JU_LVL;
      ST_F_W:      op = OP_F_W;
      ST_W_CHK: begin
        if (sts.u_zero) op = OP_FAIL;
        else if (sts.kind == KIND_LCA) op = OP_DONE_NODE;
        else op = OP_RD_DEP_U;
      end
      ST_X_D:      op = OP_DONE_DIST;
      default:     op = OP_NONE;
    endcase
  end

endmodule

@@ hdl/taqe_dp.sv @@
// datapath with depth and jump memories, working registers and result register
module taqe_dp #(
  parameter int NODE_COUNT  = 1024,
  parameter int JUMP_LEVELS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  taqe_pkg::in_t     in_data,
  input  taqe_pkg::dp_op_t  op,
  output taqe_pkg::dp_sts_t sts,
  output logic              out_strobe,
  output taqe_pkg::out_t    out_data
);
  import taqe_pkg::*;

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int AW  = $clog2(NODE_COUNT * JUMP_LEVELS);
  localparam int LW  = $clog2(JUMP_LEVELS);
  localparam int TOP = 1 << (JUMP_LEVELS - 1);
  localparam int TOP_REPEATS = (DEPTH_SPAN >> (JUMP_LEVELS - 1)) + 1;
  localparam int RW  = $clog2(TOP_REPEATS + 1);
  localparam logic [LW-1:0] LVL_TOP = LW'(JUMP_LEVELS - 1);
  localparam logic [LW-1:0] LVL_PEN = LW'(JUMP_LEVELS - 2);

  logic [NODE_W-1:0] dep_mem [NODE_COUNT];
  logic [NODE_W-1:0] jmp_mem [NODE_COUNT * JUMP_LEVELS];

  logic [1:0]        kind_r, kind_nxt;
  logic [NODE_W-1:0] a_r, a_nxt, b_r, b_nxt, steps_r, steps_nxt;
  logic [NODE_W-1:0] u_r, u_nxt, v_r, v_nxt, pu_r, pu_nxt;
  logic [NODE_W-1:0] k_r, k_nxt, du_r, du_nxt, dv_r, dv_nxt;
  logic [LW-1:0]     lvl_r, lvl_nxt;
  logic [RW-1:0]     rep_r, rep_nxt;
  logic              side_r, side_nxt;
  logic              jnull_r, jnull_nxt;
  logic              ostb_r, ostb_nxt;
  out_t              out_r, out_nxt;

  logic [NODE_W-1:0] dep_rdata_r, jmp_rdata_r;
  logic              dep_re, dep_we, jmp_re, jmp_we;
  logic [NODE_W-1:0] dep_ra_node, dep_wd, jmp_wd;
  logic [NW-1:0]     dep_wa;
  logic [AW-1:0]     jmp_ra, jmp_wa;

  logic [NODE_W-1:0] node_c, up_val;
  logic [31:0]       k_sh;

  function automatic logic nnull(input logic [NODE_W-1:0] n);
    return (n == '0) || (32'(n) >= NODE_COUNT);
  endfunction

  function automatic logic [AW-1:0] jaddr(input logic [NODE_W-1:0] n,
                                          input logic [LW-1:0] l);
    return AW'(NW'(n)) * AW'(JUMP_LEVELS) + AW'(l);
  endfunction

  assign node_c = side_r ? v_r : u_r;
  assign up_val = jnull_r ? '0 : jmp_rdata_r;
  assign k_sh   = 32'(k_r) >> lvl_r;

  always_comb begin
    sts.kind        = kind_r;
    sts.root_load   = (b_r == '0);
    if (kind_r == KIND_LOAD) begin
      sts.bad_req = nnull(a_r) || (32'(b_r) >= NODE_COUNT) || (a_r == b_r);
    end else if (kind_r == KIND_ANC) begin
      sts.bad_req = nnull(a_r);
    end else begin
      sts.bad_req = nnull(a_r) || nnull(b_r);
    end
    sts.step_over   = (steps_r > dep_rdata_r);
    sts.k_ge_top    = (32'(k_r) >= TOP);
    sts.node_c_null = nnull(node_c);
    sts.k_bit       = k_sh[0];
    sts.lvl_zero    = (lvl_r == '0);
    sts.lvl_last    = (lvl_r == LVL_TOP);
    sts.lvl_pen     = (lvl_r == LVL_PEN);
    sts.uv_eq       = (u_r == v_r);
    sts.rep_done    = (rep_r == RW'(TOP_REPEATS));
    sts.p_eq        = (pu_r == up_val);
    sts.u_zero      = (u_r == '0);
  end

  always_comb begin
    kind_nxt  = kind_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    steps_nxt = steps_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    pu_nxt    = pu_r;
    k_nxt     = k_r;
    du_nxt    = du_r;
    dv_nxt    = dv_r;
    lvl_nxt   = lvl_r;
    rep_nxt   = rep_r;
    side_nxt  = side_r;
    jnull_nxt = jnull_r;
    ostb_nxt  = 1'b0;
    out_nxt   = out_r;
    dep_re      = 1'b0;
    dep_we      = 1'b0;
    jmp_re      = 1'b0;
    jmp_we      = 1'b0;
    dep_ra_node = a_r;
    dep_wa      = NW'(a_r);
    dep_wd      = '0;
    jmp_ra      = jaddr(u_r, lvl_r);
    jmp_wa      = jaddr(a_r, lvl_r);
    jmp_wd      = '0;
    case (op)
      OP_LATCH: begin
        kind_nxt  = in_data.kind;
        a_nxt     = in_data.node_a;
        b_nxt     = in_data.node_b;
        steps_nxt = in_data.steps;
        u_nxt     = (in_data.kind == KIND_LOAD) ? in_data.node_b : in_data.node_a;
        v_nxt     = in_data.node_b;
        lvl_nxt   = '0;
        rep_nxt   = '0;
        side_nxt  = 1'b0;
      end
      OP_FAIL: begin
        ostb_nxt = 1'b1;
        out_nxt  = '{result_node: '0, result_distance: '0, status: 1'b1};
      end
      OP_ROOT_WR: begin
        dep_we  = 1'b1;
        jmp_we  = 1'b1;
        lvl_nxt = lvl_r + 1'b1;
      end
      OP_RD_DEP_B: begin
        dep_re      = 1'b1;
        dep_ra_node = b_r;
      end
      OP_LD_DW: begin
        dep_we = 1'b1;
        dep_wd = (dep_rdata_r == DEPTH_MAX) ? DEPTH_MAX : dep_rdata_r + 1'b1;
        jmp_we = 1'b1;
        jmp_wa = jaddr(a_r, '0);
        jmp_wd = b_r;
      end
      OP_RD_JU_LVL: begin
        jmp_re    = 1'b1;
        jmp_ra    = jaddr(u_r, lvl_r);
        jnull_nxt = nnull(u_r);
      end
      OP_LD_JW: begin
        jmp_we  = 1'b1;
        jmp_wa  = jaddr(a_r, lvl_r + 1'b1);
        jmp_wd  = up_val;
        u_nxt   = up_val;
        lvl_nxt = lvl_r + 1'b1;
      end
      OP_RD_DEP_A: begin
        dep_re      = 1'b1;
        dep_ra_node = a_r;
      end
      OP_Q_SET: begin
        du_nxt   = dep_rdata_r;
        k_nxt    = steps_r;
        side_nxt = 1'b0;
      end
      OP_RD_JC_TOP: begin
        jmp_re    = 1'b1;
        jmp_ra    = jaddr(node_c, LVL_TOP);
        jnull_nxt = nnull(node_c);
      end
      OP_C_TOPW: begin
        if (side_r) v_nxt = up_val;
        else u_nxt = up_val;
        k_nxt = k_r - NODE_W'(TOP);
      end
      OP_C_SETBIT: lvl_nxt = LVL_PEN;
      OP_RD_JC_LVL: begin
        jmp_re    = 1'b1;
        jmp_ra    = jaddr(node_c, lvl_r);
        jnull_nxt = nnull(node_c);
      end
      OP_C_BITW: begin
        if (side_r) v_nxt = up_val;
        else u_nxt = up_val;
        if (lvl_r != '0) lvl_nxt = lvl_r - 1'b1;
      end
      OP_LVL_DEC: if (lvl_r != '0) lvl_nxt = lvl_r - 1'b1;
      OP_DU_RD_B: begin
        du_nxt      = dep_rdata_r;
        dep_re      = 1'b1;
        dep_ra_node = b_r;
      end
      OP_EQ_SET: begin
        dv_nxt = dep_rdata_r;
        if (du_r > dep_rdata_r) begin
          side_nxt = 1'b0;
          k_nxt    = du_r - dep_rdata_r;
        end else begin
          side_nxt = 1'b1;
          k_nxt    = dep_rdata_r - du_r;
        end
      end
      OP_RD_JU_TOP: begin
        jmp_re    = 1'b1;
        jmp_ra    = jaddr(u_r, LVL_TOP);
        jnull_nxt = nnull(u_r);
      end
      OP_T_RV: begin
        pu_nxt    = up_val;
        jmp_re    = 1'b1;
        jmp_ra    = jaddr(v_r, LVL_TOP);
        jnull_nxt = nnull(v_r);
      end
      OP_T_STEP: begin
        u_nxt   = pu_r;
        v_nxt   = up_val;
        rep_nxt = rep_r + 1'b1;
      end
      OP_B_RV: begin
        pu_nxt    = up_val;
        jmp_re    = 1'b1;
        jmp_ra    = jaddr(v_r, lvl_r);
        jnull_nxt = nnull(v_r);
      end
      OP_B_STEP: begin
        if (pu_r != up_val) begin
          u_nxt = pu_r;
          v_nxt = up_val;
        end
        if (lvl_r != '0) lvl_nxt = lvl_r - 1'b1;
      end
      OP_F_W: u_nxt = up_val;
      OP_RD_DEP_U: begin
        dep_re      = 1'b1;
        dep_ra_node = u_r;
      end
      OP_DONE_NODE: begin
        ostb_nxt = 1'b1;
        out_nxt  = '{result_node: u_r, result_distance: '0, status: 1'b0};
      end
      OP_DONE_LOAD: begin
        ostb_nxt = 1'b1;
        out_nxt  = '{result_node: '0, result_distance: '0, status: 1'b0};
      end
      OP_DONE_DIST: begin
        ostb_nxt = 1'b1;
        out_nxt.result_node     = u_r;
        out_nxt.result_distance = DIST_W'(du_r) + DIST_W'(dv_r)
                                  - {dep_rdata_r, 1'b0};
        out_nxt.status          = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[dep_wa] <= dep_wd;
    if (dep_re) dep_rdata_r <= dep_mem[NW'(dep_ra_node)];
  end

  always_ff @(posedge clk) begin
    if (jmp_we) jmp_mem[jmp_wa] <= jmp_wd;
    if (jmp_re) jmp_rdata_r <= jmp_mem[jmp_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ostb_r <= 1'b0;
    end else begin
      ostb_r <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    steps_r <= steps_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    pu_r    <= pu_nxt;
    k_r     <= k_nxt;
    du_r    <= du_nxt;
    dv_r    <= dv_nxt;
    lvl_r   <= lvl_nxt;
    rep_r   <= rep_nxt;
    side_r  <= side_nxt;
    jnull_r <= jnull_nxt;
    out_r   <= out_nxt;
  end

  assign out_strobe = ostb_r;
  assign out_data   = out_r;

endmodule

@@ hdl/tree_ancestor_query_engine_top.sv @@
// top level of the binary-lifting tree ancestor query engine
// one item at a time; busy stays high from acceptance until the result beat is issued
// root load writes every jump level; child load does one jump read per level
// there is no output stall
// synchronous reset clears control only; memories hold garbage until nodes are loaded
module tree_ancestor_query_engine_top #(
  parameter int NODE_COUNT  = 1024,
  parameter int JUMP_LEVELS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  taqe_pkg::in_t  in_data,
  output logic           busy,
  output logic           out_strobe,
  output taqe_pkg::out_t out_data
);
  import taqe_pkg::*;

  dp_op_t  op;
  dp_sts_t sts;

  taqe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .op    (op)
  );

  taqe_dp #(
    .NODE_COUNT  (NODE_COUNT),
    .JUMP_LEVELS (JUMP_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .op         (op),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status) |->
      (out_data.result_node == '0 && out_data.result_distance == '0))
    else $error("failed result carries data");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("two result beats in a row");
`endif

endmodule
